@@ design/mtg_pkg.sv @@
// Package: constants, state encoding and tempering function for the MT19937 generator.
package mtg_pkg;

  localparam int MAX_KEY_WORDS = 256;
  localparam int KEY_IW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KEY_CW = $clog2(MAX_KEY_WORDS + 1);
  localparam int KLEN_MAX = (MAX_KEY_WORDS > 624) ? MAX_KEY_WORDS : 624;
  localparam int KW = $clog2(KLEN_MAX + 1);

  localparam int          STATE_WORDS = 624;
  localparam logic [9:0]  LAST_IDX    = 10'd623;
  localparam logic [9:0]  IDX_USED_UP = 10'd624;
  localparam logic [9:0]  IDX_NO_SEED = 10'd625;
  localparam logic [9:0]  SHIFT_DIST  = 10'd397;
  localparam logic [9:0]  WRAP_DIST   = 10'd227;

  localparam logic [31:0] INIT_MULT   = 32'd1812433253;
  localparam logic [31:0] KEY_SEED    = 32'd19650218;
  localparam logic [31:0] MIX1_MULT   = 32'd1664525;
  localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
  localparam logic [31:0] HIGH_BIT    = 32'h8000_0000;
  localparam logic [31:0] DEF_SEED    = 32'd5489;
  localparam logic [31:0] TWIST_CONST = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B    = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C    = 32'hEFC6_0000;

  localparam logic [1:0] MODE_SEED   = 2'd0;
  localparam logic [1:0] MODE_KEY    = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SW_INIT,
    ST_SW_MUL,
    ST_SW_WR,
    ST_KA_RD,
    ST_KA_WR,
    ST_KA_WRAP,
    ST_KEND,
    ST_TW_PRE,
    ST_TW_PRE2,
    ST_TW_RD,
    ST_TW_WR,
    ST_DR_RD,
    ST_DR_WB
  } state_e;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ design/mt19937_generator.sv @@
// Top level: MT19937 generator with state and key memories and a sequencer.
// Draw, words left: ST_DR_RD reads, ST_DR_WB tempers and waits for the output; then idle.
// Twist of all 624 words: ST_TW_PRE/PRE2 prime reads, then one read-modify-write per word.
// Single-word seed: word 0 written directly, then one multiply and one write per word.
// Array seeding: seed, then key mixing, a multiply and a write per step.
// Reset (rst_ni low, async) marks the generator unseeded and the key empty; no clearing pass.
module mt19937_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] word
  input  logic [1:0]  s_tuser,   // [1:0] mode
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] value
);

  mtg_pkg::state_e state_q, state_d;

  // State memory: one write port, two registered read ports.
  logic [31:0] ts_mem [mtg_pkg::STATE_WORDS];
  logic        ts_we;
  logic [9:0]  ts_wa, ts_ra_a, ts_ra_b;
  logic [31:0] ts_wd, rd_a_q, rd_b_q;

  // Key memory: one write port, one registered read port.
  logic [31:0] ks_mem [mtg_pkg::MAX_KEY_WORDS];
  logic        ks_we;
  logic [mtg_pkg::KEY_IW-1:0] ks_ra;
  logic [31:0] rd_k_q;

  logic [9:0]  read_idx_q;
  logic [mtg_pkg::KEY_CW-1:0] key_cnt_q, key_len_q, key_cnt_inc, j_inc;
  logic [mtg_pkg::KEY_IW-1:0] j_q;
  logic [mtg_pkg::KW-1:0] k_q;
  logic [9:0]  n_q;
  logic [31:0] p_q, m_q, cur_q, seed_val_q;
  logic        phase2_q, draw_pend_q, key_pend_q;
  logic        m_tvalid_q;
  logic [31:0] m_tdata_q;

  logic        s_acc, out_free;
  logic [31:0] mul_in, mul_k, mul_p, mix_v, twist_v, twist_y;

  assign s_tready  = (state_q == mtg_pkg::ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid_q || m_tready;
  assign m_tvalid  = m_tvalid_q;
  assign m_tdata   = m_tdata_q;

  // Shared multiplier: previous word folded, times the seeding or key-mixing constant.
  assign mul_in = p_q ^ (p_q >> 30);
  assign mul_k  = (state_q == mtg_pkg::ST_SW_MUL) ? mtg_pkg::INIT_MULT :
                  (phase2_q ? mtg_pkg::MIX2_MULT : mtg_pkg::MIX1_MULT);
  assign mul_p  = 32'(mul_in * mul_k);

  assign mix_v = phase2_q ? ((rd_a_q ^ m_q) - 32'(n_q))
                          : ((rd_a_q ^ m_q) + rd_k_q + 32'(j_q));

  assign twist_y = {cur_q[31], rd_a_q[30:0]};
  assign twist_v = rd_b_q ^ (twist_y >> 1) ^ (twist_y[0] ? mtg_pkg::TWIST_CONST : 32'd0);

  assign key_cnt_inc = key_cnt_q + mtg_pkg::KEY_CW'(1);
  assign j_inc       = mtg_pkg::KEY_CW'(j_q) + mtg_pkg::KEY_CW'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mtg_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (s_tuser)
            mtg_pkg::MODE_SEED: state_d = mtg_pkg::ST_SW_INIT;
            mtg_pkg::MODE_KEY:  state_d = s_tlast ? mtg_pkg::ST_SW_INIT : mtg_pkg::ST_IDLE;
            mtg_pkg::MODE_DRAW: begin
              if (read_idx_q == mtg_pkg::IDX_NO_SEED) state_d = mtg_pkg::ST_SW_INIT;
              else if (read_idx_q == mtg_pkg::IDX_USED_UP) state_d = mtg_pkg::ST_TW_PRE;
              else state_d = mtg_pkg::ST_DR_RD;
            end
            default: state_d = mtg_pkg::ST_IDLE;
          endcase
        end
      end
      mtg_pkg::ST_SW_INIT: state_d = mtg_pkg::ST_SW_MUL;
      mtg_pkg::ST_SW_MUL:  state_d = mtg_pkg::ST_SW_WR;
      mtg_pkg::ST_SW_WR: begin
        if (n_q == mtg_pkg::LAST_IDX) begin
          if (key_pend_q) state_d = mtg_pkg::ST_KA_RD;
          else if (draw_pend_q) state_d = mtg_pkg::ST_TW_PRE;
          else state_d = mtg_pkg::ST_IDLE;
        end else begin
          state_d = mtg_pkg::ST_SW_MUL;
        end
      end
      mtg_pkg::ST_KA_RD: state_d = mtg_pkg::ST_KA_WR;
      mtg_pkg::ST_KA_WR: begin
        if (n_q == mtg_pkg::LAST_IDX) state_d = mtg_pkg::ST_KA_WRAP;
        else if (k_q == mtg_pkg::KW'(1) && phase2_q) state_d = mtg_pkg::ST_KEND;
        else state_d = mtg_pkg::ST_KA_RD;
      end
      mtg_pkg::ST_KA_WRAP: begin
        if (k_q == '0 && phase2_q) state_d = mtg_pkg::ST_KEND;
        else state_d = mtg_pkg::ST_KA_RD;
      end
      mtg_pkg::ST_KEND:    state_d = mtg_pkg::ST_IDLE;
      mtg_pkg::ST_TW_PRE:  state_d = mtg_pkg::ST_TW_PRE2;
      mtg_pkg::ST_TW_PRE2: state_d = mtg_pkg::ST_TW_RD;
      mtg_pkg::ST_TW_RD:   state_d = mtg_pkg::ST_TW_WR;
      mtg_pkg::ST_TW_WR: begin
        if (n_q == mtg_pkg::LAST_IDX) state_d = mtg_pkg::ST_DR_RD;
        else state_d = mtg_pkg::ST_TW_RD;
      end
      mtg_pkg::ST_DR_RD: state_d = mtg_pkg::ST_DR_WB;
      mtg_pkg::ST_DR_WB: if (out_free) state_d = mtg_pkg::ST_IDLE;
      default: state_d = mtg_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    ts_we   = 1'b0;
    ts_wa   = n_q;
    ts_wd   = mix_v;
    ts_ra_a = n_q;
    ts_ra_b = n_q;
    ks_ra   = j_q;
    ks_we   = 1'b0;
    case (state_q)
      mtg_pkg::ST_IDLE: begin
        ks_we = s_acc && (s_tuser == mtg_pkg::MODE_KEY) &&
                (key_cnt_q < mtg_pkg::KEY_CW'(mtg_pkg::MAX_KEY_WORDS));
      end
      mtg_pkg::ST_SW_INIT: begin
        ts_we = 1'b1;
        ts_wa = '0;
        ts_wd = seed_val_q;
      end
      mtg_pkg::ST_SW_WR: begin
        ts_we = 1'b1;
        ts_wd = m_q + 32'(n_q);
      end
      mtg_pkg::ST_KA_WR: ts_we = 1'b1;
      mtg_pkg::ST_KA_WRAP: begin
        // Copy the last word to the head of the store.
        ts_we = 1'b1;
        ts_wa = '0;
        ts_wd = p_q;
      end
      mtg_pkg::ST_KEND: begin
        ts_we = 1'b1;
        ts_wa = '0;
        ts_wd = mtg_pkg::HIGH_BIT;
      end
      mtg_pkg::ST_TW_PRE: ts_ra_a = '0;
      mtg_pkg::ST_TW_RD: begin
        ts_ra_a = (n_q == mtg_pkg::LAST_IDX) ? 10'd0 : n_q + 10'd1;
        ts_ra_b = (n_q < mtg_pkg::WRAP_DIST) ? n_q + mtg_pkg::SHIFT_DIST
                                             : n_q - mtg_pkg::WRAP_DIST;
      end
      mtg_pkg::ST_TW_WR: begin
        ts_we = 1'b1;
        ts_wd = twist_v;
      end
      mtg_pkg::ST_DR_RD, mtg_pkg::ST_DR_WB: ts_ra_a = read_idx_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ts_we) ts_mem[ts_wa] <= ts_wd;
    rd_a_q <= ts_mem[ts_ra_a];
    rd_b_q <= ts_mem[ts_ra_b];
  end

  always_ff @(posedge clk_i) begin
    if (ks_we) ks_mem[key_cnt_q[mtg_pkg::KEY_IW-1:0]] <= s_tdata;
    rd_k_q <= ks_mem[ks_ra];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtg_pkg::ST_IDLE;
      read_idx_q  <= mtg_pkg::IDX_NO_SEED;
      key_cnt_q   <= '0;
      key_len_q   <= '0;
      draw_pend_q <= 1'b0;
      key_pend_q  <= 1'b0;
      phase2_q    <= 1'b0;
      n_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // Raise valid when a tempered word is stored, drop it once taken.
      if (state_q == mtg_pkg::ST_DR_WB && out_free) m_tvalid_q <= 1'b1;
      else if (m_tready) m_tvalid_q <= 1'b0;
      case (state_q)
        mtg_pkg::ST_IDLE: begin
          if (s_acc) begin
            case (s_tuser)
              mtg_pkg::MODE_SEED: begin
                key_pend_q  <= 1'b0;
                draw_pend_q <= 1'b0;
              end
              mtg_pkg::MODE_KEY: begin
                if (ks_we) key_cnt_q <= key_cnt_inc;
                if (s_tlast) begin
                  key_len_q   <= ks_we ? key_cnt_inc : key_cnt_q;
                  key_pend_q  <= 1'b1;
                  draw_pend_q <= 1'b0;
                end
              end
              mtg_pkg::MODE_DRAW: begin
                key_pend_q  <= 1'b0;
                draw_pend_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        mtg_pkg::ST_SW_INIT: n_q <= 10'd1;
        mtg_pkg::ST_SW_WR: begin
          n_q <= n_q + 10'd1;
          if (n_q == mtg_pkg::LAST_IDX) begin
            read_idx_q <= mtg_pkg::IDX_USED_UP;
            if (key_pend_q) begin
              n_q      <= 10'd1;
              j_q      <= '0;
              phase2_q <= 1'b0;
              k_q      <= (mtg_pkg::KW'(key_len_q) > mtg_pkg::KW'(mtg_pkg::STATE_WORDS))
                          ? mtg_pkg::KW'(key_len_q) : mtg_pkg::KW'(mtg_pkg::STATE_WORDS);
            end
          end
        end
        mtg_pkg::ST_KA_WR: begin
          n_q <= (n_q == mtg_pkg::LAST_IDX) ? 10'd1 : n_q + 10'd1;
          j_q <= (j_inc >= key_len_q) ? '0 : j_inc[mtg_pkg::KEY_IW-1:0];
          if (k_q == mtg_pkg::KW'(1)) begin
            if (phase2_q) begin
              k_q <= '0;
            end else begin
              phase2_q <= 1'b1;
              k_q      <= mtg_pkg::KW'(mtg_pkg::STATE_WORDS - 1);
            end
          end else begin
            k_q <= k_q - mtg_pkg::KW'(1);
          end
        end
        mtg_pkg::ST_KEND: begin
          read_idx_q <= mtg_pkg::IDX_USED_UP;
          key_cnt_q  <= '0;
          key_pend_q <= 1'b0;
          phase2_q   <= 1'b0;
        end
        mtg_pkg::ST_TW_PRE2: n_q <= '0;
        mtg_pkg::ST_TW_WR: begin
          n_q <= n_q + 10'd1;
          if (n_q == mtg_pkg::LAST_IDX) read_idx_q <= '0;
        end
        mtg_pkg::ST_DR_WB: begin
          if (out_free) begin
            read_idx_q  <= read_idx_q + 10'd1;
            draw_pend_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mtg_pkg::ST_IDLE: begin
        if (s_acc) begin
          case (s_tuser)
            mtg_pkg::MODE_SEED: seed_val_q <= s_tdata;
            mtg_pkg::MODE_KEY:  seed_val_q <= mtg_pkg::KEY_SEED;
            mtg_pkg::MODE_DRAW: seed_val_q <= mtg_pkg::DEF_SEED;
            default: ;
          endcase
        end
      end
      mtg_pkg::ST_SW_INIT: p_q <= seed_val_q;
      mtg_pkg::ST_SW_MUL:  m_q <= mul_p;
      // On the last word, reload word 0 so key mixing starts from the head.
      mtg_pkg::ST_SW_WR:   p_q <= (n_q == mtg_pkg::LAST_IDX) ? seed_val_q : m_q + 32'(n_q);
      mtg_pkg::ST_KA_RD:   m_q <= mul_p;
      mtg_pkg::ST_KA_WR:   p_q <= mix_v;
      mtg_pkg::ST_TW_PRE2: cur_q <= rd_a_q;
      mtg_pkg::ST_TW_WR:   cur_q <= rd_a_q;
      mtg_pkg::ST_DR_WB:   if (out_free) m_tdata_q <= mtg_pkg::temper(rd_a_q);
      default: ;
    endcase
  end

endmodule

@@ design/mtg_checker.sv @@
// Checker: port-level assertions for the MT19937 generator, bound to the top level.
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && !m_tvalid && s_tuser != mtg_pkg::MODE_DRAW |=> !m_tvalid)
    else $error("result without a draw");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser == mtg_pkg::MODE_DRAW |=> !s_tready)
    else $error("draw accepted without a memory read cycle");

endmodule

bind mt19937_generator mtg_checker u_mtg_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ dv/tb.sv @@
// Testbench for the MT19937 generator: stream stimulus, built-in predictor, result checking.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predictor and store of expected draw results.
  class mt_scoreboard;
    bit [31:0] twist_words[mtg_pkg::STATE_WORDS];
    bit [9:0]  draw_pos;
    bit [31:0] key_words[mtg_pkg::MAX_KEY_WORDS];
    int        keys_held;
    bit [31:0] pending_values[$];
    int        errors;

    function new();
      draw_pos = mtg_pkg::IDX_NO_SEED;
      keys_held = 0;
      errors = 0;
    endfunction

    function void seed_one(bit [31:0] s);
      bit [31:0] p;
      twist_words[0] = s;
      for (int n = 1; n < mtg_pkg::STATE_WORDS; n++) begin
        p = twist_words[n-1];
        twist_words[n] = mtg_pkg::INIT_MULT * (p ^ (p >> 30)) + n;
      end
      draw_pos = mtg_pkg::IDX_USED_UP;
    endfunction

    function void seed_from_key(int len);
      int i, j, k;
      bit [31:0] p, m;
      seed_one(mtg_pkg::KEY_SEED);
      i = 1;
      j = 0;
      k = (len > mtg_pkg::STATE_WORDS) ? len : mtg_pkg::STATE_WORDS;
      for (; k != 0; k--) begin
        p = twist_words[i-1];
        m = (p ^ (p >> 30)) * mtg_pkg::MIX1_MULT;
        twist_words[i] = (twist_words[i] ^ m) + key_words[j] + j;
        i++;
        j++;
        if (i >= mtg_pkg::STATE_WORDS) begin
          twist_words[0] = twist_words[mtg_pkg::STATE_WORDS-1];
          i = 1;
        end
        if (j >= len) j = 0;
      end
      for (k = mtg_pkg::STATE_WORDS - 1; k != 0; k--) begin
        p = twist_words[i-1];
        m = (p ^ (p >> 30)) * mtg_pkg::MIX2_MULT;
        twist_words[i] = (twist_words[i] ^ m) - i;
        i++;
        if (i >= mtg_pkg::STATE_WORDS) begin
          twist_words[0] = twist_words[mtg_pkg::STATE_WORDS-1];
          i = 1;
        end
      end
      twist_words[0] = mtg_pkg::HIGH_BIT;
      draw_pos = mtg_pkg::IDX_USED_UP;
    endfunction

    function void regenerate();
      bit [31:0] y;
      for (int n = 0; n < mtg_pkg::STATE_WORDS; n++) begin
        y = (twist_words[n] & mtg_pkg::HIGH_BIT)
            | (twist_words[(n+1) % mtg_pkg::STATE_WORDS] & ~mtg_pkg::HIGH_BIT);
        twist_words[n] = twist_words[(n + mtg_pkg::SHIFT_DIST) % mtg_pkg::STATE_WORDS]
                         ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_CONST : 32'd0);
      end
      draw_pos = 0;
    endfunction

    // Note one accepted input item and, for a draw, queue the value it should produce.
    function void note_input(bit [1:0] mode, bit [31:0] word, bit last);
      bit [31:0] y;
      case (mode)
        mtg_pkg::MODE_SEED: seed_one(word);
        mtg_pkg::MODE_KEY: begin
          if (keys_held < mtg_pkg::MAX_KEY_WORDS) begin
            key_words[keys_held] = word;
            keys_held++;
          end
          if (last) begin
            seed_from_key(keys_held);
            keys_held = 0;
          end
        end
        mtg_pkg::MODE_DRAW: begin
          if (draw_pos >= mtg_pkg::IDX_USED_UP) begin
            if (draw_pos == mtg_pkg::IDX_NO_SEED) seed_one(mtg_pkg::DEF_SEED);
            regenerate();
          end
          y = twist_words[draw_pos];
          draw_pos++;
          y ^= y >> 11;
          y ^= (y << 7) & mtg_pkg::TEMPER_B;
          y ^= (y << 15) & mtg_pkg::TEMPER_C;
          y ^= y >> 18;
          pending_values.push_back(y);
        end
        default: ;
      endcase
    endfunction

    function void check_value(bit [31:0] got);
      bit [31:0] want;
      if (pending_values.size() == 0) begin
        $error("value: unexpected result %h", got);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      if (want !== got) begin
        $error("value: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  mt_scoreboard mt_model = new();
  bit quiet_tail = 1'b0;  // no idling in the last part of the run
  bit stim_done  = 1'b0;

  always #4 clk_i = ~clk_i;

  mt19937_generator dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata
  );

  // Send one item: random idle burst before it, then hold until accepted.
  task automatic send_item(bit [1:0] mode, bit [31:0] word, bit last);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= word;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    mt_model.note_input(mode, word, last);
  endtask

  // Load a key of the given length, marking the last word.
  task automatic send_key(int len);
    for (int i = 0; i < len; i++)
      send_item(mtg_pkg::MODE_KEY, $urandom(), i == len - 1);
  endtask

  // Receiver: stall in random bursts, check each accepted value.
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) mt_model.check_value(m_tdata);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: draw before any seed falls back to the default seed.
    send_item(mtg_pkg::MODE_DRAW, 32'hFFFF_FFFF, 1'b1);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b0);
    send_item(mtg_pkg::MODE_UNUSED, 32'hA5A5_A5A5, 1'b1);   // unused mode does nothing
    send_item(mtg_pkg::MODE_SEED, '0, 1'b1);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b0);
    send_item(mtg_pkg::MODE_SEED, 32'hFFFF_FFFF, 1'b0);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b0);
    send_key(1);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b0);
    // Single-word seed in the middle of a key load leaves the key intact.
    send_item(mtg_pkg::MODE_KEY, 32'h0000_0000, 1'b0);
    send_item(mtg_pkg::MODE_SEED, 32'h1234_5678, 1'b0);
    send_item(mtg_pkg::MODE_KEY, 32'hFFFF_FFFF, 1'b1);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b0);
    // Overfull key: words past the store are dropped.
    send_key(mtg_pkg::MAX_KEY_WORDS + 4);
    send_item(mtg_pkg::MODE_DRAW, '0, 1'b1);
    // Run through a whole store so the next draw regenerates.
    for (int i = 0; i < mtg_pkg::STATE_WORDS + 2; i++)
      send_item(mtg_pkg::MODE_DRAW, $urandom(), 1'b0);

    // Random part, mostly draws with occasional seeding and unused-mode items.
    for (int i = 0; i < 800; i++) begin
      if (i > 700) quiet_tail = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 2) send_item(mtg_pkg::MODE_SEED, $urandom(), $urandom_range(0, 1));
      else if (r < 3) send_key($urandom_range(1, 6));
      else if (r < 4) send_item(mtg_pkg::MODE_UNUSED, $urandom(), $urandom_range(0, 1));
      else send_item(mtg_pkg::MODE_DRAW, $urandom(), $urandom_range(0, 1));
    end
    s_tvalid <= 1'b0;

    while (mt_model.pending_values.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    stim_done = 1'b1;
    if (mt_model.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #40ms;
    if (!stim_done) begin
      $display("Verification failed");
      $finish;
    end
  end
endmodule

@@ filelist.f @@
design/mtg_pkg.sv
design/mt19937_generator.sv
design/mtg_checker.sv
dv/tb.sv
